// ===== rtl/core/qmd_pkg.sv =====
// Shared types and constants for the queue with middle delete.
package qmd_pkg;

    // Default number of entries held by the queue.
    localparam int CAPACITY_DEF = 16;

    // Field widths of the transactions.
    localparam int ACT_W = 2;
    localparam int VAL_W = 32;
    localparam int OCC_W = 5;

    // Action codes carried by an input transaction.
    localparam logic [ACT_W-1:0] ACT_APPEND     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP_HEAD   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_POP_MIDDLE = 2'd2;

    // Status codes carried by a result transaction.
    typedef enum logic [1:0] {
        ST_APPENDED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Input transaction payload.
    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic signed [VAL_W-1:0] value;
    } t_in_data;

    // Result transaction payload.
    typedef struct packed {
        t_status                 status;
        logic signed [VAL_W-1:0] removed_value;
        logic [OCC_W-1:0]        occupancy;
    } t_out_data;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic append;
        logic remove;
    } t_cell_op;

endpackage

// ===== rtl/core/qmd_cell.sv =====
// One storage cell of the queue chain: holds one entry and shifts toward the head.
module qmd_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic                             i_clk,
    input  qmd_pkg::t_cell_op                i_op,
    input  logic [CNT_W-1:0]                 i_count,
    input  logic [CNT_W-1:0]                 i_pos,
    input  logic signed [qmd_pkg::VAL_W-1:0] i_append_value,
    input  logic signed [qmd_pkg::VAL_W-1:0] i_next_value,
    output logic signed [qmd_pkg::VAL_W-1:0] o_value,
    output logic [qmd_pkg::VAL_W-1:0]        o_taken
);

    localparam logic [CNT_W:0] MY_IDX   = (CNT_W+1)'(INDEX);
    localparam logic [CNT_W:0] NEXT_IDX = (CNT_W+1)'(INDEX + 1);

    logic signed [qmd_pkg::VAL_W-1:0] r_value;
    logic signed [qmd_pkg::VAL_W-1:0] n_value;
    logic                             w_at_tail;
    logic                             w_at_pos;
    logic                             w_shift;

    // Position compares against the broadcast count and removal point.
    assign w_at_tail = ({1'b0, i_count} == MY_IDX);
    assign w_at_pos  = ({1'b0, i_pos} == MY_IDX);
    assign w_shift   = ({1'b0, i_pos} <= MY_IDX) && (NEXT_IDX < {1'b0, i_count});

    // Next entry value: take the appended value, the neighbor's value, or hold.
    always_comb begin
        n_value = r_value;
        if (i_op.append && w_at_tail) begin
            n_value = i_append_value;
        end else if (i_op.remove && w_shift) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // The removed entry drives its value onto the shared OR bus.
    assign o_taken = (i_op.remove && w_at_pos) ? r_value : '0;
    assign o_value = r_value;

endmodule

// ===== rtl/core/queue_with_middle_delete_unit.sv =====
// Top level of the queue with middle delete: control, cell chain and result register.
//
//   Channel | Direction | Handshake                  | Payload
//   in      | input     | i_in_valid / o_in_ready    | i_in_data  (action, value)
//   out     | output    | o_out_valid / i_out_ready  | o_out_data (status, removed_value,
//           |           |                            |             occupancy)
//
// Every input transaction is done on the accepting edge: the affected cells update in parallel
// on that edge and the result lands in the output register.
// One transaction per cycle is sustained while the output is taken; the single
// output register sets that figure, and o_in_ready drops while it holds an untaken result.
// Synchronous active-low reset empties the queue and the output register.
// Entry contents are not cleared by reset; only entries below the count are read.
module queue_with_middle_delete_unit #(
    parameter int CAPACITY = qmd_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  qmd_pkg::t_in_data   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output qmd_pkg::t_out_data  o_out_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]                 r_count;
    logic [CNT_W-1:0]                 n_count;
    logic                             r_out_valid;
    qmd_pkg::t_out_data               r_out_data;
    qmd_pkg::t_out_data               n_out_data;
    logic                             w_accept;
    logic                             w_full;
    logic                             w_empty;
    logic [CNT_W-1:0]                 w_pos;
    qmd_pkg::t_cell_op                w_op;
    logic signed [qmd_pkg::VAL_W-1:0] w_cell_value [CAPACITY];
    logic [qmd_pkg::VAL_W-1:0]        w_cell_taken [CAPACITY];
    logic [qmd_pkg::VAL_W-1:0]        w_removed;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_full     = (r_count == CAP_CNT);
    assign w_empty    = (r_count == '0);

    // Decode the transaction into a cell operation and a removal point.
    always_comb begin
        w_op        = '0;
        w_pos       = '0;
        n_count     = r_count;
        n_out_data  = '0;
        n_out_data.status = qmd_pkg::ST_EMPTY;
        unique case (i_in_data.action)
            qmd_pkg::ACT_APPEND: begin
                if (w_full) begin
                    n_out_data.status = qmd_pkg::ST_FULL;
                end else begin
                    w_op.append       = w_accept;
                    n_count           = r_count + 1'b1;
                    n_out_data.status = qmd_pkg::ST_APPENDED;
                end
            end
            qmd_pkg::ACT_POP_HEAD, qmd_pkg::ACT_POP_MIDDLE: begin
                if (!w_empty) begin
                    if (i_in_data.action == qmd_pkg::ACT_POP_MIDDLE
                            && r_count > CNT_W'(2)) begin
                        w_pos = r_count >> 1;
                    end
                    w_op.remove       = w_accept;
                    n_count           = r_count - 1'b1;
                    n_out_data.status = qmd_pkg::ST_REMOVED;
                end
            end
            default: begin
                n_out_data.status = qmd_pkg::ST_EMPTY;
            end
        endcase
        n_out_data.removed_value = w_removed;
        n_out_data.occupancy     = qmd_pkg::OCC_W'(n_count);
    end

    // Chain of cells; the last cell has no neighbor behind it.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [qmd_pkg::VAL_W-1:0] w_next;
        if (g == CAPACITY - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_cell_value[g+1];
        end
        qmd_cell #(
            .INDEX (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk          (i_clk),
            .i_op           (w_op),
            .i_count        (r_count),
            .i_pos          (w_pos),
            .i_append_value (i_in_data.value),
            .i_next_value   (w_next),
            .o_value        (w_cell_value[g]),
            .o_taken        (w_cell_taken[g])
        );
    end

    // Only the cell at the removal point drives a nonzero value.
    always_comb begin
        w_removed = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_removed = w_removed | w_cell_taken[k];
        end
    end

    // Count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/core/qmd_checker.sv =====
// Port-level checks for the queue with middle delete, bound to the top level.
module qmd_checker #(
    parameter int CAPACITY = qmd_pkg::CAPACITY_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input qmd_pkg::t_out_data o_out_data
);

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Every accepted transaction shows a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted transaction gave no result");

    // Only a removal carries a nonzero removed value.
    a_removed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != qmd_pkg::ST_REMOVED
            |-> o_out_data.removed_value == '0)
        else $error("removed value set without a removal");

    // A rejected append reports a full queue.
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == qmd_pkg::ST_FULL
            |-> o_out_data.occupancy == qmd_pkg::OCC_W'(CAPACITY))
        else $error("full status with wrong occupancy");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind queue_with_middle_delete_unit qmd_checker #(
    .CAPACITY (CAPACITY)
) u_qmd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== tb/sv/tb_queue_with_middle_delete_unit.sv =====
// Self-checking testbench for the queue with middle delete: directed table and random traffic.
`timescale 1ns / 1ps

module tb_queue_with_middle_delete_unit;

    // Local names for the package widths, types and codes used throughout.
    localparam int ACT_W = qmd_pkg::ACT_W;
    localparam int VAL_W = qmd_pkg::VAL_W;
    localparam int OCC_W = qmd_pkg::OCC_W;

    typedef qmd_pkg::t_in_data  t_in_data;
    typedef qmd_pkg::t_out_data t_out_data;

    localparam logic [ACT_W-1:0] ACT_APPEND     = qmd_pkg::ACT_APPEND;
    localparam logic [ACT_W-1:0] ACT_POP_HEAD   = qmd_pkg::ACT_POP_HEAD;
    localparam logic [ACT_W-1:0] ACT_POP_MIDDLE = qmd_pkg::ACT_POP_MIDDLE;

    localparam qmd_pkg::t_status ST_APPENDED = qmd_pkg::ST_APPENDED;
    localparam qmd_pkg::t_status ST_REMOVED  = qmd_pkg::ST_REMOVED;
    localparam qmd_pkg::t_status ST_EMPTY    = qmd_pkg::ST_EMPTY;
    localparam qmd_pkg::t_status ST_FULL     = qmd_pkg::ST_FULL;

    localparam int QUEUE_DEPTH  = qmd_pkg::CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1625;
    localparam int IDLE_LIMIT   = 2000;
    localparam int REPORT_LIMIT = 10;

    // Action code 3 is not defined by the block; the queue must ignore it.
    localparam logic [ACT_W-1:0] ACT_UNDEFINED = 2'd3;

    // Receiver stall behaviors, drawn anew at random whenever the low six bits of rx_cycle are zero.
    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_PATTERN,
        RX_LONG_STALL
    } t_stall_mode;

    // One row of the directed table; its result is only used when fixed is set, else the predictor's is.
    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic signed [VAL_W-1:0] value;
        logic                    fixed;
        t_out_data               result;
    } t_directed_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_data    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_data   o_out_data;

    // Side information that travels with the transaction being offered.
    logic        row_fixed = 1'b0;
    t_out_data   row_result = '0;

    // Predictor state and the results still owed by the block.
    logic signed [VAL_W-1:0] model_entries[$];
    t_out_data               expected_results[$];

    int          accepted_items = 0;
    int          checked_results = 0;
    int          mismatch_count = 0;
    int          rejected_appends = 0;
    int          empty_removes = 0;
    int          deep_middle_removes = 0;
    int          idle_cycles = 0;

    int unsigned rx_cycle = 0;
    t_stall_mode rx_mode = RX_FREE;

    // Directed sequence: empty-store cases, undefined codes, extremes, short middle removal, fill, full, pops.
    t_directed_row directed_rows [0:24] = '{
        '{ACT_POP_HEAD,   32'sh0000_0000, 1'b1, '{ST_EMPTY,    32'sh0000_0000, 5'd0}},
        '{ACT_POP_MIDDLE, 32'sh0000_0000, 1'b1, '{ST_EMPTY,    32'sh0000_0000, 5'd0}},
        '{ACT_UNDEFINED,  32'shFFFF_FFFF, 1'b1, '{ST_EMPTY,    32'sh0000_0000, 5'd0}},
        '{ACT_APPEND,     32'sh7FFF_FFFF, 1'b1, '{ST_APPENDED, 32'sh0000_0000, 5'd1}},
        '{ACT_APPEND,     32'sh8000_0000, 1'b1, '{ST_APPENDED, 32'sh0000_0000, 5'd2}},
        '{ACT_POP_MIDDLE, 32'sh1234_5678, 1'b1, '{ST_REMOVED,  32'sh7FFF_FFFF, 5'd1}},
        '{ACT_APPEND,     32'sh0000_0000, 1'b0, '{ST_APPENDED, 32'sh0000_0000, 5'd0}},
        '{ACT_APPEND,     32'shFFFF_FFFF, 1'b0, '{ST_APPENDED, 32'sh0000_0000, 5'd0}},
        '{ACT_APPEND,     32'sh0000_0001, 1'b0, '{ST_APPENDED, 32'sh0000_0000, 5'd0}},
        '{ACT_APPEND,     32'sh5555_5555, 1'b0, '{ST_APPENDED, 32'sh0000_0000, 5'd0}},
        '{ACT_APPEND,     32'shAAAA_AAAA, 1'b0, '{ST_APPENDED, 32'sh0000_0000, 5'd0}},
        '{ACT_APPEND,     32'sh0000_0002, 1'b0, '{ST_APPENDED, 32'sh0000_0000, 5'd0}},
        '{ACT_APPEND,     32'sh0000_0003, 1'b0, '{ST_APPENDED, 32'sh0000_0000, 5'd0}},
        '{ACT_APPEND,     32'sh0000_0004, 1'b0, '{ST_APPENDED, 32'sh0000_0000, 5'd0}},
        '{ACT_APPEND,     32'sh0000_0005, 1'b0, '{ST_APPENDED, 32'sh0000_0000, 5'd0}},
        '{ACT_APPEND,     32'sh0000_0006, 1'b0, '{ST_APPENDED, 32'sh0000_0000, 5'd0}},
        '{ACT_APPEND,     32'sh0000_0007, 1'b0, '{ST_APPENDED, 32'sh0000_0000, 5'd0}},
        '{ACT_APPEND,     32'sh0000_0008, 1'b0, '{ST_APPENDED, 32'sh0000_0000, 5'd0}},
        '{ACT_APPEND,     32'sh0F0F_0F0F, 1'b0, '{ST_APPENDED, 32'sh0000_0000, 5'd0}},
        '{ACT_APPEND,     32'shF0F0_F0F0, 1'b0, '{ST_APPENDED, 32'sh0000_0000, 5'd0}},
        '{ACT_APPEND,     32'shFFFF_FFFE, 1'b1, '{ST_APPENDED, 32'sh0000_0000, 5'd16}},
        '{ACT_APPEND,     32'sh7FFF_FFFF, 1'b1, '{ST_FULL,     32'sh0000_0000, 5'd16}},
        '{ACT_UNDEFINED,  32'sh0000_0000, 1'b1, '{ST_EMPTY,    32'sh0000_0000, 5'd16}},
        '{ACT_POP_MIDDLE, 32'sh0000_0000, 1'b0, '{ST_APPENDED, 32'sh0000_0000, 5'd0}},
        '{ACT_POP_HEAD,   32'sh0000_0000, 1'b1, '{ST_REMOVED,  32'sh8000_0000, 5'd14}}
    };

    queue_with_middle_delete_unit #(
        .CAPACITY(QUEUE_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // Apply one command to the predicted queue and return the result it must produce.
    function automatic t_out_data queue_step(input t_in_data cmd);
        t_out_data   res;
        int unsigned pos;
        res.status        = ST_EMPTY;
        res.removed_value = '0;
        case (cmd.action)
            ACT_APPEND: begin
                if (model_entries.size() >= QUEUE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    model_entries.push_back(cmd.value);
                    res.status = ST_APPENDED;
                end
            end
            ACT_POP_HEAD, ACT_POP_MIDDLE: begin
                if (model_entries.size() != 0) begin
                    pos = 0;
                    // With one or two entries a middle removal takes the head.
                    if (cmd.action == ACT_POP_MIDDLE && model_entries.size() > 2)
                        pos = model_entries.size() / 2;
                    res.removed_value = model_entries[pos];
                    model_entries.delete(pos);
                    res.status = ST_REMOVED;
                end
            end
            default: begin
            end
        endcase
        res.occupancy = OCC_W'(model_entries.size());
        return res;
    endfunction

    // Mix of uniform values, small magnitudes and the signed extremes.
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return VAL_W'($signed($urandom_range(0, 16)) - 8);
            default: return $urandom;
        endcase
    endfunction

    // Receiver: ready follows a stall behavior that is drawn anew whenever the low six bits of rx_cycle are zero.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle[5:0] == 6'd0)
            rx_mode <= t_stall_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_FREE:       i_out_ready <= 1'b1;
            RX_RANDOM:     i_out_ready <= 1'($urandom_range(0, 1));
            RX_PATTERN:    i_out_ready <= (rx_cycle[1:0] != 2'd0);
            RX_LONG_STALL: i_out_ready <= (rx_cycle[3:0] > 4'd6);
            default:       i_out_ready <= 1'b1;
        endcase
    end

    // Monitor: check the result transaction first, then predict for the accepted command.
    always @(posedge i_clk) begin : monitor
        t_out_data want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                checked_results++;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result: status=%0d removed=%0d occupancy=%0d",
                                 o_out_data.status, $signed(o_out_data.removed_value),
                                 o_out_data.occupancy);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data.status !== want.status ||
                        o_out_data.removed_value !== want.removed_value ||
                        o_out_data.occupancy !== want.occupancy) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display({"result %0d: expected status=%0d removed=%0d ",
                                      "occupancy=%0d, got status=%0d removed=%0d occupancy=%0d"},
                                     checked_results, want.status,
                                     $signed(want.removed_value), want.occupancy,
                                     o_out_data.status, $signed(o_out_data.removed_value),
                                     o_out_data.occupancy);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                if (i_in_data.action == ACT_POP_MIDDLE && model_entries.size() > 2)
                    deep_middle_removes++;
                want = queue_step(i_in_data);
                if (want.status == ST_FULL)
                    rejected_appends++;
                if (want.status == ST_EMPTY && i_in_data.action != ACT_UNDEFINED)
                    empty_removes++;
                // Rows with a hand-written result are held to it rather than to the predictor.
                if (row_fixed)
                    want = row_result;
                expected_results.push_back(want);
                accepted_items++;
            end
            // Watchdog on cycles without any transaction.
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("timeout after %0d idle cycles", idle_cycles);
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    // Offer one command and hold it until the block accepts it.
    task automatic offer_command(input t_in_data cmd, input logic fixed, input t_out_data res);
        i_in_valid <= 1'b1;
        i_in_data  <= cmd;
        row_fixed  <= fixed;
        row_result <= res;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Random traffic in bursts; each burst leans toward filling or draining the queue.
    task automatic send_random(input int count);
        int       sent;
        int       burst;
        int       gap;
        int       append_share;
        int       pick;
        int       k;
        t_in_data cmd;
        sent = 0;
        while (sent < count) begin
            burst        = $urandom_range(1, 24);
            append_share = $urandom_range(20, 80);
            for (k = 0; k < burst && sent < count; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    cmd.action = ACT_UNDEFINED;
                else if (pick < 4 + append_share)
                    cmd.action = ACT_APPEND;
                else if ($urandom_range(0, 2) != 0)
                    cmd.action = ACT_POP_MIDDLE;
                else
                    cmd.action = ACT_POP_HEAD;
                cmd.value = pick_value();
                offer_command(cmd, 1'b0, '0);
                sent++;
                if (sent == count / 2)
                    wait_for_results();
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Main sequence: reset, directed table, random traffic, drain, verdict.
    initial begin : stimulus
        int       r;
        t_in_data cmd;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (r = 0; r < $size(directed_rows); r++) begin
            cmd.action = directed_rows[r].action;
            cmd.value  = directed_rows[r].value;
            offer_command(cmd, directed_rows[r].fixed, directed_rows[r].result);
        end
        wait_for_results();
        send_random(RANDOM_ITEMS);
        wait_for_results();
        repeat (8) @(posedge i_clk);
        $display("covered %0d commands and %0d results, %0d middle removals past the head",
                 accepted_items, checked_results, deep_middle_removes);
        $display("full-queue rejects: %0d, removals from an empty queue: %0d, mismatches: %0d",
                 rejected_appends, empty_removes, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
